### design/c8alu_pkg.sv
// shared types and operation codes for the cpu8 alu/register/flag execute block
// no dependencies; used by c8alu_core and cpu8_alu_register_flag_execute
`default_nettype none

package c8alu_pkg;

  typedef enum logic [5:0] {
    OP_ADC  = 6'd0,
    OP_AND  = 6'd1,
    OP_ORA  = 6'd2,
    OP_EOR  = 6'd3,
    OP_CMP  = 6'd4,
    OP_CPX  = 6'd5,
    OP_CPY  = 6'd6,
    OP_LDA  = 6'd7,
    OP_LDX  = 6'd8,
    OP_LDY  = 6'd9,
    OP_INC  = 6'd10,
    OP_DEC  = 6'd11,
    OP_INX  = 6'd12,
    OP_INY  = 6'd13,
    OP_DEX  = 6'd14,
    OP_DEY  = 6'd15,
    OP_ROLA = 6'd16,
    OP_RORA = 6'd17,
    OP_ROLM = 6'd18,
    OP_RORM = 6'd19,
    OP_TAX  = 6'd20,
    OP_TAY  = 6'd21,
    OP_TXA  = 6'd22,
    OP_TYA  = 6'd23,
    OP_TSX  = 6'd24,
    OP_TXS  = 6'd25,
    OP_CLC  = 6'd26,
    OP_SEC  = 6'd27,
    OP_CLD  = 6'd28,
    OP_SED  = 6'd29,
    OP_CLI  = 6'd30,
    OP_SEI  = 6'd31,
    OP_CLV  = 6'd32,
    OP_BRT  = 6'd33,
    OP_STA  = 6'd34,
    OP_STX  = 6'd35,
    OP_STY  = 6'd36,
    OP_NOP  = 6'd37
  } op_t;

  // branch flag selector
  localparam logic [1:0] BR_C = 2'd0;
  localparam logic [1:0] BR_Z = 2'd1;
  localparam logic [1:0] BR_N = 2'd2;
  localparam logic [1:0] BR_V = 2'd3;

  localparam logic [7:0] SP_RESET = 8'hFF;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  // architectural state
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] xr;
    logic [7:0] yr;
    logic [7:0] sp;
    flags_t     fl;
  } arch_t;

  // per-operation side results
  typedef struct packed {
    logic [7:0] write_value;
    logic       write_enable;
    logic       branch_taken;
  } side_t;

  // pack flags as N V 1 0 D I Z C
  function automatic logic [7:0] status_byte(flags_t f);
    status_byte = {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
  endfunction

endpackage

`default_nettype wire

### design/cpu8_alu_register_flag_execute.sv
// out_tready low stalls the result register and then the input register
// one word per cycle unless stalled; input register -> core logic -> result register
// the next word executes against the state left by the previous one in the same stage
// reset (rst_n low, synchronous): A, X, Y and flags cleared, stack pointer 0xFF,
// both pipeline stages emptied
// depends on c8alu_pkg and c8alu_core
`default_nettype none

module cpu8_alu_register_flag_execute (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // operand[7:0], branch_flag[9:8], branch_sense[10], zero
  input  wire logic [5:0]  in_tuser,   // operation[5:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // write_value[7:0], write_enable[8], acc_out[16:9], xreg_out[24:17], yreg_out[32:25],
  // stack_out[40:33], status_out[48:41], branch_taken[49], zero
  output logic [55:0]      out_tdata
);

  // input stage
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  c8alu_pkg::op_t      s1_op_r;
  logic [7:0]          s1_operand_r;
  logic [1:0]          s1_bflag_r;
  logic                s1_bsense_r;

  // architectural state
  c8alu_pkg::arch_t    arch_r;
  c8alu_pkg::arch_t    arch_nxt;
  c8alu_pkg::side_t    side;

  // result stage
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [55:0]         out_data_r;
  logic [55:0]         out_data_nxt;

  logic                in_fire;
  logic                exec_fire;

  assign exec_fire = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || exec_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (exec_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = exec_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  c8alu_core u_core (
    .op           (s1_op_r),
    .operand      (s1_operand_r),
    .branch_flag  (s1_bflag_r),
    .branch_sense (s1_bsense_r),
    .cur          (arch_r),
    .nxt          (arch_nxt),
    .side         (side)
  );

  assign out_data_nxt = {6'd0,
                         side.branch_taken,
                         c8alu_pkg::status_byte(arch_nxt.fl),
                         arch_nxt.sp,
                         arch_nxt.yr,
                         arch_nxt.xr,
                         arch_nxt.acc,
                         side.write_enable,
                         side.write_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      arch_r      <= '{acc: 8'd0, xr: 8'd0, yr: 8'd0, sp: c8alu_pkg::SP_RESET, fl: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        arch_r <= arch_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= c8alu_pkg::op_t'(in_tuser);
      s1_operand_r <= in_tdata[7:0];
      s1_bflag_r   <= in_tdata[9:8];
      s1_bsense_r  <= in_tdata[10];
    end
    if (exec_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an empty result register never holds back the input side
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // fixed status bits: bit 5 set, bit 4 clear
  a_status_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[46] == 1'b1) && (out_data_r[45] == 1'b0))
    else $error("status fixed bits wrong");

  // a memory write and a taken branch never come from one operation
  a_write_or_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[8] && out_data_r[49]))
    else $error("write and branch taken together");

  // only a transfer from X moves the stack pointer
  a_sp_only_txs: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (arch_r.sp != $past(arch_r.sp))) |->
      $past(exec_fire && (s1_op_r == c8alu_pkg::OP_TXS)))
    else $error("stack pointer changed without txs");

endmodule

`default_nettype wire

### design/c8alu_core.sv
// combinational execute logic: next architectural state and side results
// depends on c8alu_pkg
`default_nettype none

module c8alu_core (
  input  var c8alu_pkg::op_t   op,
  input  wire logic [7:0]      operand,
  input  wire logic [1:0]      branch_flag,
  input  wire logic            branch_sense,
  input  var c8alu_pkg::arch_t cur,
  output c8alu_pkg::arch_t     nxt,
  output c8alu_pkg::side_t     side
);

  logic [8:0] sum9;
  logic [7:0] sum8;
  logic [7:0] cmp_reg;
  logic [8:0] diff9;
  logic [7:0] rot_src;
  logic [7:0] rol_val;
  logic [7:0] ror_val;
  logic [7:0] inc_val;
  logic [7:0] dec_val;
  logic       sel_flag;

  assign sum9    = {1'b0, cur.acc} + {1'b0, operand} + {8'd0, cur.fl.c};
  assign sum8    = sum9[7:0];
  assign diff9   = {1'b0, cmp_reg} - {1'b0, operand};
  assign rot_src = (op == c8alu_pkg::OP_ROLA || op == c8alu_pkg::OP_RORA) ? cur.acc : operand;
  assign rol_val = {rot_src[6:0], cur.fl.c};
  assign ror_val = {cur.fl.c, rot_src[7:1]};
  assign inc_val = operand + 8'd1;
  assign dec_val = operand - 8'd1;

  always_comb begin
    case (op)
      c8alu_pkg::OP_CPX: cmp_reg = cur.xr;
      c8alu_pkg::OP_CPY: cmp_reg = cur.yr;
      default:           cmp_reg = cur.acc;
    endcase
  end

  always_comb begin
    case (branch_flag)
      c8alu_pkg::BR_C: sel_flag = cur.fl.c;
      c8alu_pkg::BR_Z: sel_flag = cur.fl.z;
      c8alu_pkg::BR_N: sel_flag = cur.fl.n;
      c8alu_pkg::BR_V: sel_flag = cur.fl.v;
      default:         sel_flag = cur.fl.c;
    endcase
  end

  always_comb begin
    logic [7:0] nz_src;
    logic       nz_upd;
    nxt    = cur;
    side   = '0;
    nz_src = 8'd0;
    nz_upd = 1'b0;
    case (op)
      c8alu_pkg::OP_ADC: begin
        nxt.acc  = sum8;
        nxt.fl.c = sum9[8];
        nxt.fl.v = (cur.acc[7] ^ sum8[7]) & (operand[7] ^ sum8[7]);
        nz_src   = sum8;
        nz_upd   = 1'b1;
      end
      c8alu_pkg::OP_AND: begin
        nxt.acc = cur.acc & operand;
        nz_src  = cur.acc & operand;
        nz_upd  = 1'b1;
      end
      c8alu_pkg::OP_ORA: begin
        nxt.acc = cur.acc | operand;
        nz_src  = cur.acc | operand;
        nz_upd  = 1'b1;
      end
      c8alu_pkg::OP_EOR: begin
        nxt.acc = cur.acc ^ operand;
        nz_src  = cur.acc ^ operand;
        nz_upd  = 1'b1;
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        // borrow clear means operand <= register
        nxt.fl.c = ~diff9[8];
        nxt.fl.n = diff9[7];
        nxt.fl.z = (diff9[7:0] == 8'd0);
      end
      c8alu_pkg::OP_LDA: begin
        nxt.acc = operand;
        nz_src  = operand;
        nz_upd  = 1'b1;
      end
      c8alu_pkg::OP_LDX: begin
        nxt.xr = operand;
        nz_src = operand;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_LDY: begin
        nxt.yr = operand;
        nz_src = operand;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_INC: begin
        side.write_value  = inc_val;
        side.write_enable = 1'b1;
        nz_src            = inc_val;
        nz_upd            = 1'b1;
      end
      c8alu_pkg::OP_DEC: begin
        side.write_value  = dec_val;
        side.write_enable = 1'b1;
        nz_src            = dec_val;
        nz_upd            = 1'b1;
      end
      c8alu_pkg::OP_INX: begin
        nxt.xr = cur.xr + 8'd1;
        nz_src = cur.xr + 8'd1;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_INY: begin
        nxt.yr = cur.yr + 8'd1;
        nz_src = cur.yr + 8'd1;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_DEX: begin
        nxt.xr = cur.xr - 8'd1;
        nz_src = cur.xr - 8'd1;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_DEY: begin
        nxt.yr = cur.yr - 8'd1;
        nz_src = cur.yr - 8'd1;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_ROLA: begin
        nxt.acc  = rol_val;
        nxt.fl.c = rot_src[7];
        nz_src   = rol_val;
        nz_upd   = 1'b1;
      end
      c8alu_pkg::OP_RORA: begin
        nxt.acc  = ror_val;
        nxt.fl.c = rot_src[0];
        nz_src   = ror_val;
        nz_upd   = 1'b1;
      end
      c8alu_pkg::OP_ROLM: begin
        side.write_value  = rol_val;
        side.write_enable = 1'b1;
        nxt.fl.c          = rot_src[7];
        nz_src            = rol_val;
        nz_upd            = 1'b1;
      end
      c8alu_pkg::OP_RORM: begin
        side.write_value  = ror_val;
        side.write_enable = 1'b1;
        nxt.fl.c          = rot_src[0];
        nz_src            = ror_val;
        nz_upd            = 1'b1;
      end
      c8alu_pkg::OP_TAX: begin
        nxt.xr = cur.acc;
        nz_src = cur.acc;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_TAY: begin
        nxt.yr = cur.acc;
        nz_src = cur.acc;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_TXA: begin
        nxt.acc = cur.xr;
        nz_src  = cur.xr;
        nz_upd  = 1'b1;
      end
      c8alu_pkg::OP_TYA: begin
        nxt.acc = cur.yr;
        nz_src  = cur.yr;
        nz_upd  = 1'b1;
      end
      c8alu_pkg::OP_TSX: begin
        nxt.xr = cur.sp;
        nz_src = cur.sp;
        nz_upd = 1'b1;
      end
      c8alu_pkg::OP_TXS: nxt.sp   = cur.xr;
      c8alu_pkg::OP_CLC: nxt.fl.c = 1'b0;
      c8alu_pkg::OP_SEC: nxt.fl.c = 1'b1;
      c8alu_pkg::OP_CLD: nxt.fl.d = 1'b0;
      c8alu_pkg::OP_SED: nxt.fl.d = 1'b1;
      c8alu_pkg::OP_CLI: nxt.fl.i = 1'b0;
      c8alu_pkg::OP_SEI: nxt.fl.i = 1'b1;
      c8alu_pkg::OP_CLV: nxt.fl.v = 1'b0;
      c8alu_pkg::OP_BRT: side.branch_taken = (sel_flag == branch_sense);
      c8alu_pkg::OP_STA: begin
        side.write_value  = cur.acc;
        side.write_enable = 1'b1;
      end
      c8alu_pkg::OP_STX: begin
        side.write_value  = cur.xr;
        side.write_enable = 1'b1;
      end
      c8alu_pkg::OP_STY: begin
        side.write_value  = cur.yr;
        side.write_enable = 1'b1;
      end
      default: ;  // nop and unused codes
    endcase
    if (nz_upd) begin
      nxt.fl.n = nz_src[7];
      nxt.fl.z = (nz_src == 8'd0);
    end
  end

endmodule

`default_nettype wire

### verif/tb_cpu8_alu_register_flag_execute.sv
// testbench for cpu8_alu_register_flag_execute: directed table then random operations,
// every result word checked, the first PIN_N against pinned_tab, the rest against a
// register/flag predictor kept in this file; depends on c8alu_pkg and the design sources
`default_nettype none

module tb_cpu8_alu_register_flag_execute;

  localparam int RAND_N     = 900;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 8;
  localparam logic [5:0] UNUSED_OP = 6'd63;

  typedef struct {
    logic [5:0] op;
    logic [7:0] opnd;
    logic [1:0] bflag;
    logic       bsense;
  } op_word_t;

  typedef struct packed {
    logic [7:0] wval;
    logic       wen;
    logic [7:0] acc;
    logic [7:0] xr;
    logic [7:0] yr;
    logic [7:0] sp;
    logic [7:0] status;
    logic       taken;
  } exec_word_t;

  localparam int DIR_N = 47;
  op_word_t dir_tab [DIR_N] = '{
    '{c8alu_pkg::OP_NOP,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_LDA,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_LDA,  8'h80, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_LDA,  8'hFF, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_ADC,  8'h01, c8alu_pkg::BR_C, 1'b0},   // wraps to zero with carry out
    '{c8alu_pkg::OP_ADC,  8'h7F, c8alu_pkg::BR_C, 1'b0},   // carry in, signed overflow to 0x80
    '{c8alu_pkg::OP_BRT,  8'h00, c8alu_pkg::BR_V, 1'b1},
    '{c8alu_pkg::OP_BRT,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CLV,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_ADC,  8'h80, c8alu_pkg::BR_C, 1'b0},   // negative plus negative overflows
    '{c8alu_pkg::OP_BRT,  8'h00, c8alu_pkg::BR_Z, 1'b1},
    '{c8alu_pkg::OP_BRT,  8'h00, c8alu_pkg::BR_N, 1'b0},
    '{c8alu_pkg::OP_AND,  8'h0F, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_ORA,  8'hF0, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_EOR,  8'hFF, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CMP,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_LDX,  8'hFF, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CPX,  8'hFF, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_LDY,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CPY,  8'h01, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_INC,  8'hFF, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_DEC,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_INX,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_INY,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_DEX,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_DEY,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_SEC,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_ROLA, 8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_RORA, 8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_ROLM, 8'h80, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_RORM, 8'h01, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_TAX,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_TAY,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_TXA,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_TYA,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_TSX,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_TXS,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CLC,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_SED,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CLD,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_SEI,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_CLI,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_STA,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_STX,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{c8alu_pkg::OP_STY,  8'h00, c8alu_pkg::BR_C, 1'b0},
    '{UNUSED_OP, 8'hFF, c8alu_pkg::BR_V, 1'b1},
    '{c8alu_pkg::OP_NOP,  8'hFF, c8alu_pkg::BR_V, 1'b1}
  };

  // results of the first table rows, straight from reset
  localparam int PIN_N = 3;
  exec_word_t pinned_tab [PIN_N] = '{
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h20, 1'b0},
    '{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h22, 1'b0},
    '{8'h00, 1'b0, 8'h80, 8'h00, 8'h00, 8'hFF, 8'hA0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [5:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  cpu8_alu_register_flag_execute u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted architectural state
  logic [7:0]        acc_m = 8'h00;
  logic [7:0]        x_m   = 8'h00;
  logic [7:0]        y_m   = 8'h00;
  logic [7:0]        sp_m  = c8alu_pkg::SP_RESET;
  c8alu_pkg::flags_t fl_m  = '0;

  exec_word_t exp_word_q [$];
  int         words_in = 0;
  int         err_count = 0;
  int         idle_cycles = 0;

  function automatic void put_nz(logic [7:0] v);
    fl_m.n = v[7];
    fl_m.z = (v == 8'h00);
  endfunction

  function automatic void cmp_flags(logic [7:0] r, logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    fl_m.c = (m <= r);
    fl_m.n = diff[7];
    fl_m.z = (r == m);
  endfunction

  function automatic logic [7:0] rol_c(logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], fl_m.c};
    fl_m.c = v[7];
    put_nz(r);
    return r;
  endfunction

  function automatic logic [7:0] ror_c(logic [7:0] v);
    logic [7:0] r;
    r = {fl_m.c, v[7:1]};
    fl_m.c = v[0];
    put_nz(r);
    return r;
  endfunction

  function automatic exec_word_t execute_op(op_word_t o);
    exec_word_t w;
    logic [8:0] sum;
    logic [7:0] r;
    logic       fv;
    w = '0;
    case (o.op)
      c8alu_pkg::OP_ADC: begin
        sum = {1'b0, acc_m} + {1'b0, o.opnd} + {8'h00, fl_m.c};
        r = sum[7:0];
        fl_m.c = sum[8];
        fl_m.v = (acc_m[7] ^ r[7]) & (o.opnd[7] ^ r[7]);
        acc_m = r;
        put_nz(r);
      end
      c8alu_pkg::OP_AND: begin acc_m = acc_m & o.opnd; put_nz(acc_m); end
      c8alu_pkg::OP_ORA: begin acc_m = acc_m | o.opnd; put_nz(acc_m); end
      c8alu_pkg::OP_EOR: begin acc_m = acc_m ^ o.opnd; put_nz(acc_m); end
      c8alu_pkg::OP_CMP: cmp_flags(acc_m, o.opnd);
      c8alu_pkg::OP_CPX: cmp_flags(x_m, o.opnd);
      c8alu_pkg::OP_CPY: cmp_flags(y_m, o.opnd);
      c8alu_pkg::OP_LDA: begin acc_m = o.opnd; put_nz(o.opnd); end
      c8alu_pkg::OP_LDX: begin x_m = o.opnd; put_nz(o.opnd); end
      c8alu_pkg::OP_LDY: begin y_m = o.opnd; put_nz(o.opnd); end
      c8alu_pkg::OP_INC: begin w.wval = o.opnd + 8'h01; w.wen = 1'b1; put_nz(w.wval); end
      c8alu_pkg::OP_DEC: begin w.wval = o.opnd - 8'h01; w.wen = 1'b1; put_nz(w.wval); end
      c8alu_pkg::OP_INX: begin x_m = x_m + 8'h01; put_nz(x_m); end
      c8alu_pkg::OP_INY: begin y_m = y_m + 8'h01; put_nz(y_m); end
      c8alu_pkg::OP_DEX: begin x_m = x_m - 8'h01; put_nz(x_m); end
      c8alu_pkg::OP_DEY: begin y_m = y_m - 8'h01; put_nz(y_m); end
      c8alu_pkg::OP_ROLA: acc_m = rol_c(acc_m);
      c8alu_pkg::OP_RORA: acc_m = ror_c(acc_m);
      c8alu_pkg::OP_ROLM: begin w.wval = rol_c(o.opnd); w.wen = 1'b1; end
      c8alu_pkg::OP_RORM: begin w.wval = ror_c(o.opnd); w.wen = 1'b1; end
      c8alu_pkg::OP_TAX: begin x_m = acc_m; put_nz(x_m); end
      c8alu_pkg::OP_TAY: begin y_m = acc_m; put_nz(y_m); end
      c8alu_pkg::OP_TXA: begin acc_m = x_m; put_nz(acc_m); end
      c8alu_pkg::OP_TYA: begin acc_m = y_m; put_nz(acc_m); end
      c8alu_pkg::OP_TSX: begin x_m = sp_m; put_nz(x_m); end
      c8alu_pkg::OP_TXS: sp_m = x_m;
      c8alu_pkg::OP_CLC: fl_m.c = 1'b0;
      c8alu_pkg::OP_SEC: fl_m.c = 1'b1;
      c8alu_pkg::OP_CLD: fl_m.d = 1'b0;
      c8alu_pkg::OP_SED: fl_m.d = 1'b1;
      c8alu_pkg::OP_CLI: fl_m.i = 1'b0;
      c8alu_pkg::OP_SEI: fl_m.i = 1'b1;
      c8alu_pkg::OP_CLV: fl_m.v = 1'b0;
      c8alu_pkg::OP_BRT: begin
        case (o.bflag)
          c8alu_pkg::BR_C: fv = fl_m.c;
          c8alu_pkg::BR_Z: fv = fl_m.z;
          c8alu_pkg::BR_N: fv = fl_m.n;
          default:         fv = fl_m.v;
        endcase
        w.taken = (fv == o.bsense);
      end
      c8alu_pkg::OP_STA: begin w.wval = acc_m; w.wen = 1'b1; end
      c8alu_pkg::OP_STX: begin w.wval = x_m; w.wen = 1'b1; end
      c8alu_pkg::OP_STY: begin w.wval = y_m; w.wen = 1'b1; end
      default: ;   // nop and the unused codes
    endcase
    w.acc = acc_m;
    w.xr = x_m;
    w.yr = y_m;
    w.sp = sp_m;
    w.status = {fl_m.n, fl_m.v, 1'b1, 1'b0, fl_m.d, fl_m.i, fl_m.z, fl_m.c};
    return w;
  endfunction

  // predict on every accepted input word, check every accepted result word
  always @(posedge clk) begin
    op_word_t   o;
    exec_word_t p;
    exec_word_t got;
    exec_word_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_tvalid && in_tready) begin
        o.op = in_tuser;
        o.opnd = in_tdata[7:0];
        o.bflag = in_tdata[9:8];
        o.bsense = in_tdata[10];
        p = execute_op(o);
        exp_word_q.push_back(words_in < PIN_N ? pinned_tab[words_in] : p);
        words_in = words_in + 1;
      end
      if (out_tvalid && out_tready) begin
        got.wval = out_tdata[7:0];
        got.wen = out_tdata[8];
        got.acc = out_tdata[16:9];
        got.xr = out_tdata[24:17];
        got.yr = out_tdata[32:25];
        got.sp = out_tdata[40:33];
        got.status = out_tdata[48:41];
        got.taken = out_tdata[49];
        if (exp_word_q.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = exp_word_q.pop_front();
          if (got.wval !== want.wval || got.wen !== want.wen || got.acc !== want.acc ||
              got.xr !== want.xr || got.yr !== want.yr || got.sp !== want.sp ||
              got.status !== want.status || got.taken !== want.taken) begin
            err_count = err_count + 1;
            if (err_count <= 10) begin
              $display("mismatch: exp wv=%h we=%b a=%h x=%h y=%h s=%h p=%h bt=%b",
                       want.wval, want.wen, want.acc, want.xr, want.yr, want.sp,
                       want.status, want.taken);
              $display("          got wv=%h we=%b a=%h x=%h y=%h s=%h p=%h bt=%b",
                       got.wval, got.wen, got.acc, got.xr, got.yr, got.sp,
                       got.status, got.taken);
            end
          end
        end
      end
    end
  end

  // result side backpressure, with calm stretches
  initial begin
    int stall;
    int n;
    bit calm;
    n = 0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n = n + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  int  sent = 0;
  bit  in_calm = 1'b0;

  task automatic send_word(op_word_t o);
    int gap;
    if (sent % 50 == 0) in_calm = ($urandom_range(0, 2) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= o.op;
    in_tdata <= {5'b00000, o.bsense, o.bflag, o.opnd};
    do @(posedge clk); while (!in_tready);
    sent = sent + 1;
  endtask

  initial begin
    op_word_t o;
    logic [7:0] edge_vals [4];
    edge_vals = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++) send_word(dir_tab[i]);
    for (int i = 0; i < RAND_N; i++) begin
      // unused codes now and then, operands biased toward the byte edges
      if ($urandom_range(0, 19) == 0) o.op = 6'($urandom_range(38, 63));
      else o.op = 6'($urandom_range(0, 37));
      if ($urandom_range(0, 7) == 0) o.opnd = edge_vals[$urandom_range(0, 3)];
      else o.opnd = 8'($urandom_range(0, 255));
      o.bflag = 2'($urandom_range(0, 3));
      o.bsense = 1'($urandom_range(0, 1));
      send_word(o);
    end
    in_tvalid <= 1'b0;
    while (exp_word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/c8alu_pkg.sv
design/c8alu_core.sv
design/cpu8_alu_register_flag_execute.sv
verif/tb_cpu8_alu_register_flag_execute.sv
